[rtl/apt_pkg.sv]
// Shared constants, types and field codes for the affine point transform.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package apt_pkg;

	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int MAT_ROWS   = 3;
	localparam int MAT_COLS   = 4;
	localparam int ROW_BITS   = 2;
	localparam int COL_BITS   = 2;
	localparam int PROD_BITS  = 2 * COORD_BITS;
	localparam int ACC_BITS   = PROD_BITS + 2;

	localparam int IN_FIELD_BITS  = ROW_BITS + COL_BITS + 4 * COORD_BITS;
	localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_BITS = 3 * COORD_BITS;
	localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_POINT = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [ACC_BITS-1:0]   acc_t;
	typedef logic        [ROW_BITS-1:0]   row_idx_t;
	typedef logic        [COL_BITS-1:0]   col_idx_t;

	// Pipeline control handed from one stage to the next.
	typedef struct packed {
		logic adv;
		logic vld;
	} stage_ctl_t;

endpackage

[rtl/apt_mul_stage.sv]
// First pipeline stage: nine signed products and the translation terms.
// Depends on apt_pkg.
`timescale 1ns / 1ps

module apt_mul_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  apt_pkg::stage_ctl_t ctl,
	input  apt_pkg::coord_t    mat [apt_pkg::MAT_ROWS][apt_pkg::MAT_COLS],
	input  apt_pkg::coord_t    pt  [3],
	output logic               vld_s1,
	output apt_pkg::prod_t     prod_s1 [apt_pkg::MAT_ROWS][3],
	output apt_pkg::acc_t      bias_s1 [apt_pkg::MAT_ROWS]
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ctl.adv) begin
			vld_s1 <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			for (int r = 0; r < apt_pkg::MAT_ROWS; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= apt_pkg::prod_t'(mat[r][c]) * apt_pkg::prod_t'(pt[c]);
				end
				// w is one in fixed point, so the last column is just scaled
				bias_s1[r] <= apt_pkg::acc_t'(mat[r][apt_pkg::MAT_COLS-1]) <<<
					apt_pkg::FRAC_BITS;
			end
		end
	end

endmodule

[rtl/apt_sum_stage.sv]
// Second and third pipeline stages: two-level adder tree per matrix row.
// Depends on apt_pkg.
`timescale 1ns / 1ps

module apt_sum_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  apt_pkg::stage_ctl_t ctl,
	input  apt_pkg::prod_t     prod [apt_pkg::MAT_ROWS][3],
	input  apt_pkg::acc_t      bias [apt_pkg::MAT_ROWS],
	output logic               vld_s3,
	output apt_pkg::acc_t      sum_s3 [apt_pkg::MAT_ROWS]
);

	logic          vld_s2;
	apt_pkg::acc_t pa_s2 [apt_pkg::MAT_ROWS];
	apt_pkg::acc_t pb_s2 [apt_pkg::MAT_ROWS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (ctl.adv) begin
			vld_s2 <= ctl.vld;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			for (int r = 0; r < apt_pkg::MAT_ROWS; r++) begin
				pa_s2[r]  <= apt_pkg::acc_t'(prod[r][0]) + apt_pkg::acc_t'(prod[r][1]);
				pb_s2[r]  <= apt_pkg::acc_t'(prod[r][2]) + bias[r];
				sum_s3[r] <= pa_s2[r] + pb_s2[r];
			end
		end
	end

endmodule

[rtl/apt_sat_stage.sv]
// Fourth pipeline stage and output register: rescale, range check, clip.
// Depends on apt_pkg.
`timescale 1ns / 1ps

module apt_sat_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  apt_pkg::stage_ctl_t ctl,
	input  apt_pkg::acc_t      sum [apt_pkg::MAT_ROWS],
	output logic               vld_s4,
	output apt_pkg::coord_t    res_s4 [apt_pkg::MAT_ROWS],
	output logic               sat_s4
);

	localparam int HI_BITS = apt_pkg::ACC_BITS - apt_pkg::COORD_BITS + 1;

	apt_pkg::acc_t   shifted [apt_pkg::MAT_ROWS];
	apt_pkg::coord_t clip    [apt_pkg::MAT_ROWS];
	logic [apt_pkg::MAT_ROWS-1:0] over;
	logic [HI_BITS-1:0] hi [apt_pkg::MAT_ROWS];

	always_comb begin
		for (int r = 0; r < apt_pkg::MAT_ROWS; r++) begin
			shifted[r] = sum[r] >>> apt_pkg::FRAC_BITS;
			// in range only if every bit above the result's sign bit matches it
			hi[r]      = shifted[r][apt_pkg::ACC_BITS-1:apt_pkg::COORD_BITS-1];
			over[r]    = !((hi[r] == '0) || (hi[r] == '1));
			if (!over[r]) begin
				clip[r] = shifted[r][apt_pkg::COORD_BITS-1:0];
			end else if (shifted[r][apt_pkg::ACC_BITS-1]) begin
				clip[r] = {1'b1, {(apt_pkg::COORD_BITS-1){1'b0}}};
			end else begin
				clip[r] = {1'b0, {(apt_pkg::COORD_BITS-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (ctl.adv) begin
			vld_s4 <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			for (int r = 0; r < apt_pkg::MAT_ROWS; r++) begin
				res_s4[r] <= clip[r];
			end
			sat_s4 <= |over;
		end
	end

endmodule

[rtl/affine_point_transform.sv]
// Path: a point transfer passes the stage registers s1, s2, s3 and s4 in turn, and its
// result shows on m_tvalid once it sits in s4.
// Throughput: one item per cycle through the four-stage multiply/add/clip pipeline;
// the whole pipeline holds only while a result waits in the output register.
// Load items update the matrix at acceptance and leave no trace in the pipeline.
// Reset (arst_n low) clears the matrix rows to zero and empties the pipeline.
`timescale 1ns / 1ps

module affine_point_transform (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata from bit 0: entry_row[2], entry_col[2], entry_value[32],
	// point_x[32], point_y[32], point_z[32], zero fill
	input  logic [apt_pkg::IN_DATA_BITS-1:0]  s_tdata,
	// s_tuser: operation[1]
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata from bit 0: out_x[32], out_y[32], out_z[32]
	output logic [apt_pkg::OUT_DATA_BITS-1:0] m_tdata,
	// m_tuser: saturated[1]
	output logic                              m_tuser
);

	localparam int C = apt_pkg::COORD_BITS;
	localparam int VAL_LO = apt_pkg::ROW_BITS + apt_pkg::COL_BITS;

	apt_pkg::coord_t    mat_q [apt_pkg::MAT_ROWS][apt_pkg::MAT_COLS];
	apt_pkg::coord_t    pt [3];
	apt_pkg::row_idx_t  entry_row;
	apt_pkg::col_idx_t  entry_col;
	apt_pkg::coord_t    entry_value;
	apt_pkg::stage_ctl_t ctl_mul, ctl_sum, ctl_sat;
	apt_pkg::prod_t     prod_s1 [apt_pkg::MAT_ROWS][3];
	apt_pkg::acc_t      bias_s1 [apt_pkg::MAT_ROWS];
	apt_pkg::acc_t      sum_s3 [apt_pkg::MAT_ROWS];
	apt_pkg::coord_t    res_s4 [apt_pkg::MAT_ROWS];
	logic               vld_s1, vld_s3, vld_s4, sat_s4;
	logic               adv;
	logic               load_xfer;

	assign entry_row   = s_tdata[apt_pkg::ROW_BITS-1:0];
	assign entry_col   = s_tdata[VAL_LO-1:apt_pkg::ROW_BITS];
	assign entry_value = s_tdata[VAL_LO+C-1:VAL_LO];
	assign pt[0]       = s_tdata[VAL_LO+2*C-1:VAL_LO+C];
	assign pt[1]       = s_tdata[VAL_LO+3*C-1:VAL_LO+2*C];
	assign pt[2]       = s_tdata[VAL_LO+4*C-1:VAL_LO+3*C];

	// advance everything unless a result is held at the output
	assign adv       = !m_tvalid || m_tready;
	assign s_tready  = adv;
	assign load_xfer = s_tvalid && adv && (s_tuser == apt_pkg::OP_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < apt_pkg::MAT_ROWS; r++) begin
				for (int c = 0; c < apt_pkg::MAT_COLS; c++) begin
					mat_q[r][c] <= '0;
				end
			end
		end else if (load_xfer) begin
			for (int r = 0; r < apt_pkg::MAT_ROWS; r++) begin
				for (int c = 0; c < apt_pkg::MAT_COLS; c++) begin
					// row three never matches, so its writes drop
					if ((entry_row == apt_pkg::row_idx_t'(r)) &&
					    (entry_col == apt_pkg::col_idx_t'(c))) begin
						mat_q[r][c] <= entry_value;
					end
				end
			end
		end
	end

	assign ctl_mul = '{adv: adv, vld: s_tvalid && (s_tuser == apt_pkg::OP_POINT)};
	assign ctl_sum = '{adv: adv, vld: vld_s1};
	assign ctl_sat = '{adv: adv, vld: vld_s3};

	apt_mul_stage u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_mul),
		.mat     (mat_q),
		.pt      (pt),
		.vld_s1  (vld_s1),
		.prod_s1 (prod_s1),
		.bias_s1 (bias_s1)
	);

	apt_sum_stage u_sum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_sum),
		.prod   (prod_s1),
		.bias   (bias_s1),
		.vld_s3 (vld_s3),
		.sum_s3 (sum_s3)
	);

	apt_sat_stage u_sat (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_sat),
		.sum    (sum_s3),
		.vld_s4 (vld_s4),
		.res_s4 (res_s4),
		.sat_s4 (sat_s4)
	);

	assign m_tvalid = vld_s4;
	assign m_tuser  = sat_s4;
	assign m_tdata  = apt_pkg::OUT_DATA_BITS'({res_s4[2], res_s4[1], res_s4[0]});

	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while output is held");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		load_xfer |=> !vld_s1)
		else $error("load transfer entered the pipeline");

	a_point_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == apt_pkg::OP_POINT)) |=> vld_s1)
		else $error("point transfer lost at pipeline entry");

	a_sat_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |->
		((res_s4[0] == {1'b0, {(C-1){1'b1}}}) || (res_s4[0] == {1'b1, {(C-1){1'b0}}}) ||
		 (res_s4[1] == {1'b0, {(C-1){1'b1}}}) || (res_s4[1] == {1'b1, {(C-1){1'b0}}}) ||
		 (res_s4[2] == {1'b0, {(C-1){1'b1}}}) || (res_s4[2] == {1'b1, {(C-1){1'b0}}})))
		else $error("saturation flagged without a clipped coordinate");

endmodule
